FILE: rtl/kiss_command_frame_parser_defines.svh
// ----------------------------------------------------------------------------
// KISS command frame parser - assertion macros
// Shared concurrent assertion helpers, all clocked on clock and disabled
// while reset is high.
// ----------------------------------------------------------------------------
`ifndef KISS_COMMAND_FRAME_PARSER_DEFINES_SVH
`define KISS_COMMAND_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication
`define KCFP_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("kcfp same-cycle check failed");

// Next-cycle implication
`define KCFP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("kcfp next-cycle check failed");

`endif

FILE: rtl/kcfp_pkg.sv
// ----------------------------------------------------------------------------
// kcfp_pkg
// Types and constants shared by the KISS command frame parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kcfp_pkg;

   // Framing bytes
   localparam logic [7:0] FRAME_END  = 8'hC0;
   localparam logic [7:0] FRAME_TYPE = 8'h00;

   // Printable range
   localparam logic [7:0] PRINT_LO = 8'h21;
   localparam logic [7:0] PRINT_HI = 8'h7E;

   // Command code letters: letter N pairs with digit N+1
   localparam logic [7:0] CMD_LETTER_FIRST = 8'h41;  // 'A'
   localparam logic [7:0] CMD_LETTER_LAST  = 8'h48;  // 'H'
   localparam logic [7:0] CMD_DIGIT_OFFSET = 8'h10;  // 'A' - '1'
   localparam logic [7:0] CMD_UNDEFINED    = 8'd8;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_NONE      = 2'd0,
      KIND_CHAR      = 2'd1,
      KIND_CALL_DONE = 2'd2,
      KIND_COMMAND   = 2'd3
   } kind_type;

   // One result item
   typedef struct packed {
      kind_type   kind;
      logic [7:0] value;
      logic       finished;
   } result_type;

   function automatic logic is_printable(input logic [7:0] b);
      return (b >= PRINT_LO) && (b <= PRINT_HI);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/kcfp_fsm.sv
// ----------------------------------------------------------------------------
// kcfp_fsm
// Frame parsing state machine: holds the parse state and the current token,
// and forms the result for the byte offered this cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kcfp_fsm (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,          // item accepted this cycle
   input  wire logic [7:0]          data_byte,
   input  wire logic                buffer_start,
   output kcfp_pkg::result_type     result
);

   typedef enum logic [2:0] {
      ST_NO_FRAME    = 3'd0,
      ST_FRAME_START = 3'd1,
      ST_BLANK_FIRST = 3'd2,
      ST_CALLSIGN    = 3'd3,
      ST_BLANK       = 3'd4,
      ST_TOKEN       = 3'd5
   } state_type;

   state_type  state_ff,   state_in;
   logic       stopped_ff, stopped_in;
   logic [1:0] tok_len_ff, tok_len_in;
   logic [7:0] tok_one_ff, tok_one_in;
   logic [7:0] tok_two_ff, tok_two_in;

   // State as seen by this byte, after an optional restart
   state_type  cur_state;
   logic       cur_stopped;
   logic [1:0] cur_len;
   logic [7:0] cur_one;
   logic [7:0] cur_two;
   logic       printable;
   logic [7:0] cmd_code;

   assign cur_state   = buffer_start ? ST_NO_FRAME : state_ff;
   assign cur_stopped = buffer_start ? 1'b0 : stopped_ff;
   assign cur_len     = buffer_start ? 2'd0 : tok_len_ff;
   assign cur_one     = buffer_start ? 8'd0 : tok_one_ff;
   assign cur_two     = buffer_start ? 8'd0 : tok_two_ff;
   assign printable   = kcfp_pkg::is_printable(data_byte);

   // Two-character code match: letter A..H followed by its digit 1..8
   always_comb begin
      cmd_code = kcfp_pkg::CMD_UNDEFINED;
      if (cur_len == 2'd2 &&
          cur_one >= kcfp_pkg::CMD_LETTER_FIRST &&
          cur_one <= kcfp_pkg::CMD_LETTER_LAST &&
          cur_two == cur_one - kcfp_pkg::CMD_DIGIT_OFFSET) begin
         cmd_code = cur_one - kcfp_pkg::CMD_LETTER_FIRST;
      end
   end

   // Next state and result
   always_comb begin
      state_in   = cur_state;
      stopped_in = cur_stopped;
      tok_len_in = cur_len;
      tok_one_in = cur_one;
      tok_two_in = cur_two;
      result.kind  = kcfp_pkg::KIND_NONE;
      result.value = 8'd0;

      if (!cur_stopped) begin
         case (cur_state)
            ST_NO_FRAME: begin
               if (data_byte == kcfp_pkg::FRAME_END) state_in = ST_FRAME_START;
               else                                  stopped_in = 1'b1;
            end
            ST_FRAME_START: begin
               if (data_byte == kcfp_pkg::FRAME_TYPE) state_in = ST_BLANK_FIRST;
               else                                   stopped_in = 1'b1;
            end
            ST_BLANK_FIRST: begin
               if (data_byte == kcfp_pkg::FRAME_END) begin
                  stopped_in = 1'b1;
               end else if (printable) begin
                  result.kind  = kcfp_pkg::KIND_CHAR;
                  result.value = data_byte;
                  state_in     = ST_CALLSIGN;
               end
            end
            ST_CALLSIGN: begin
               if (data_byte == kcfp_pkg::FRAME_END) begin
                  result.kind = kcfp_pkg::KIND_CALL_DONE;
                  stopped_in  = 1'b1;
               end else if (printable) begin
                  result.kind  = kcfp_pkg::KIND_CHAR;
                  result.value = data_byte;
               end else begin
                  result.kind = kcfp_pkg::KIND_CALL_DONE;
                  state_in    = ST_BLANK;
               end
            end
            ST_BLANK: begin
               if (data_byte == kcfp_pkg::FRAME_END) begin
                  stopped_in = 1'b1;
               end else if (printable) begin
                  // new token starts with this character
                  tok_len_in = 2'd1;
                  tok_one_in = data_byte;
                  tok_two_in = 8'd0;
                  state_in   = ST_TOKEN;
               end
            end
            ST_TOKEN: begin
               if (printable) begin
                  if (cur_len == 2'd0) tok_one_in = data_byte;
                  if (cur_len == 2'd1) tok_two_in = data_byte;
                  if (cur_len != 2'd3) tok_len_in = cur_len + 2'd1;
               end else begin
                  result.kind  = kcfp_pkg::KIND_COMMAND;
                  result.value = cmd_code;
                  tok_len_in   = 2'd0;
                  tok_one_in   = 8'd0;
                  tok_two_in   = 8'd0;
                  if (data_byte == kcfp_pkg::FRAME_END) stopped_in = 1'b1;
                  else                                  state_in   = ST_BLANK;
               end
            end
            default: begin
               stopped_in = 1'b1;
            end
         endcase
      end
      result.finished = stopped_in;
   end

   // State registers, advanced once per accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_NO_FRAME;
         stopped_ff <= 1'b0;
         tok_len_ff <= 2'd0;
         tok_one_ff <= 8'd0;
         tok_two_ff <= 8'd0;
      end else if (step) begin
         state_ff   <= state_in;
         stopped_ff <= stopped_in;
         tok_len_ff <= tok_len_in;
         tok_one_ff <= tok_one_in;
         tok_two_ff <= tok_two_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/kiss_command_frame_parser.sv
// ----------------------------------------------------------------------------
// kiss_command_frame_parser
// Byte-wide KISS command frame parser with a registered result channel.
// ----------------------------------------------------------------------------
// Each accepted byte yields exactly one result item in the next cycle. The
// parse state machine updates in the same cycle the byte is accepted and the
// result lands in a single output register, so a new byte is taken every
// cycle while that register is empty or being drained, stalling only while
// rsp_stall holds a full output register. Setting req_buffer_start restarts
// parsing at that byte. A result with kind 1 is a callsign character, kind 2
// marks callsign end, kind 3 carries a command code (0..7, 8 for unknown), and
// rsp_finished reports that later bytes are ignored until the next restart.
`timescale 1ns / 1ps
`default_nettype none
`include "kiss_command_frame_parser_defines.svh"

module kiss_command_frame_parser (
   input  wire logic       clock,
   input  wire logic       reset,
   // input channel
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_buffer_start,
   // result channel
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [1:0]      rsp_kind,
   output logic [7:0]      rsp_value,
   output logic            rsp_finished
);

   logic                 req_accept;
   kcfp_pkg::result_type step_result;

   logic                 rsp_valid_ff, rsp_valid_in;
   kcfp_pkg::result_type rsp_data_ff;

   // Take a byte whenever the output register is free or being emptied
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   kcfp_fsm u_fsm (
      .clock        (clock),
      .reset        (reset),
      .step         (req_accept),
      .data_byte    (req_data_byte),
      .buffer_start (req_buffer_start),
      .result       (step_result)
   );

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept)      rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_data_ff.kind;
   assign rsp_value    = rsp_data_ff.value;
   assign rsp_finished = rsp_data_ff.finished;

   // Checks
   `KCFP_ASSERT_SAME(a_stall_only_when_full, req_stall, rsp_valid)
   `KCFP_ASSERT_NEXT(a_accept_gives_result, req_accept, rsp_valid)
   `KCFP_ASSERT_SAME(a_char_printable,
      rsp_valid && rsp_kind == kcfp_pkg::KIND_CHAR,
      rsp_value >= kcfp_pkg::PRINT_LO && rsp_value <= kcfp_pkg::PRINT_HI)
   `KCFP_ASSERT_SAME(a_command_range,
      rsp_valid && rsp_kind == kcfp_pkg::KIND_COMMAND,
      rsp_value <= kcfp_pkg::CMD_UNDEFINED)
   `KCFP_ASSERT_SAME(a_marker_no_value,
      rsp_valid && (rsp_kind == kcfp_pkg::KIND_NONE ||
                    rsp_kind == kcfp_pkg::KIND_CALL_DONE),
      rsp_value == 8'd0)

endmodule

`default_nettype wire
